[hdl/crfe_pkg.sv]
package crfe_pkg;

   // Field widths of the command, result and register beats
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned COORD_W   = 11;
   localparam int unsigned SIZE_W    = 10;
   localparam int unsigned COLOR_W   = 16;
   localparam int unsigned CFG_W     = 10;
   localparam int unsigned CSR_IDX_W = 2;

   // Span coordinates: a position plus a size, signed
   localparam int unsigned SPAN_CW = 13;

   // Widest address that position arithmetic can produce
   localparam int unsigned ADDR_MIN_W = 21;

   // Default store geometry
   localparam int unsigned MAX_WIDTH_DEF  = 512;
   localparam int unsigned MAX_HEIGHT_DEF = 512;

   // Command modes
   localparam logic [MODE_W-1:0] MODE_FILL    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OUTLINE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE   = 2'd2;

   // Register reset values
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 10'd480;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 10'd320;
   localparam logic [CFG_W-1:0] ROW_STRIDE_RST   = 10'd480;

   typedef struct packed {
      logic [CFG_W-1:0] frame_width;
      logic [CFG_W-1:0] frame_height;
      logic [CFG_W-1:0] row_stride;
   } cfg_type;

   // One clipped span walk: origin, size, color and access kind
   typedef struct packed {
      logic [SPAN_CW-1:0] x0;
      logic [SPAN_CW-1:0] y0;
      logic [SIZE_W-1:0]  w;
      logic [SIZE_W-1:0]  h;
      logic [COLOR_W-1:0] color;
      logic               rd;
   } span_cmd_type;

endpackage

[hdl/crfe_req_if.sv]
interface crfe_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [crfe_pkg::MODE_W-1:0]             mode;
   logic signed [crfe_pkg::COORD_W-1:0]     pos_x;
   logic signed [crfe_pkg::COORD_W-1:0]     pos_y;
   logic [crfe_pkg::SIZE_W-1:0]             size_w;
   logic [crfe_pkg::SIZE_W-1:0]             size_h;
   logic [crfe_pkg::COLOR_W-1:0]            color;

   modport source (output valid, mode, pos_x, pos_y, size_w, size_h, color, input ready);
   modport sink (input valid, mode, pos_x, pos_y, size_w, size_h, color, output ready);
endinterface

[hdl/crfe_rsp_if.sv]
interface crfe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [crfe_pkg::COLOR_W-1:0] read_color;
   logic                         in_frame;

   modport source (output valid, read_color, in_frame, input ready);
   modport sink (input valid, read_color, in_frame, output ready);
endinterface

[hdl/crfe_csr_if.sv]
interface crfe_csr_if;
   logic                           valid;
   logic                           ready;
   logic [crfe_pkg::CSR_IDX_W-1:0] index;
   logic [crfe_pkg::CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hdl/crfe_ram.sv]
module crfe_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/crfe_span.sv]
module crfe_span #(
   parameter int unsigned DEPTH = crfe_pkg::MAX_WIDTH_DEF * crfe_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  crfe_pkg::span_cmd_type         cmd,
   input  crfe_pkg::cfg_type              cfg,
   output logic                           mem_we,
   output logic                           mem_re,
   output logic [$clog2(DEPTH)-1:0]       mem_addr,
   output logic [crfe_pkg::COLOR_W-1:0]   mem_wdata,
   output logic                           done
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = (AW > crfe_pkg::ADDR_MIN_W) ? AW : crfe_pkg::ADDR_MIN_W;
   localparam logic [CW:0] DEPTH_C = (CW+1)'(DEPTH);
   localparam int unsigned SW = crfe_pkg::SPAN_CW;
   localparam int unsigned PW = 2 * crfe_pkg::CFG_W;

   localparam logic [2:0] SP_IDLE  = 3'd0;
   localparam logic [2:0] SP_SETUP = 3'd1;
   localparam logic [2:0] SP_BASE  = 3'd2;
   localparam logic [2:0] SP_WALK  = 3'd3;
   localparam logic [2:0] SP_DONE  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [SW-1:0]                 xs_ff, xs_in, xe_ff, xe_in;
   logic [SW-1:0]                 ys_ff, ys_in, ye_ff, ye_in;
   logic [crfe_pkg::CFG_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]                 row_ff, row_in, addr_ff, addr_in;
   logic [crfe_pkg::COLOR_W-1:0]  color_ff, color_in;
   logic                          rd_ff, rd_in;

   logic [SW-1:0]                 x1, y1, fw_s, fh_s;
   logic [PW-1:0]                 prod;
   logic                          empty, x_last, y_last, in_range;

   // Clip the span against the visible frame
   always_comb begin
      fw_s = SW'(cfg.frame_width);
      fh_s = SW'(cfg.frame_height);
      x1   = cmd.x0 + SW'(cmd.w);
      y1   = cmd.y0 + SW'(cmd.h);
   end

   assign empty    = ($signed(xs_ff) >= $signed(xe_ff)) || ($signed(ys_ff) >= $signed(ye_ff));
   assign prod     = ys_ff[crfe_pkg::CFG_W-1:0] * cfg.row_stride;
   assign x_last   = ((crfe_pkg::CFG_W+1)'(x_ff) + (crfe_pkg::CFG_W+1)'(1)) ==
                     xe_ff[crfe_pkg::CFG_W:0];
   assign y_last   = ((crfe_pkg::CFG_W+1)'(y_ff) + (crfe_pkg::CFG_W+1)'(1)) ==
                     ye_ff[crfe_pkg::CFG_W:0];
   assign in_range = {1'b0, addr_ff} < DEPTH_C;

   // Sequence setup, row base and the pixel walk
   always_comb begin
      state_in = state_ff;
      xs_in    = xs_ff;
      xe_in    = xe_ff;
      ys_in    = ys_ff;
      ye_in    = ye_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      row_in   = row_ff;
      addr_in  = addr_ff;
      color_in = color_ff;
      rd_in    = rd_ff;
      unique case (state_ff)
         SP_IDLE: begin
            if (start) begin
               xs_in    = cmd.x0[SW-1] ? '0 : cmd.x0;
               ys_in    = cmd.y0[SW-1] ? '0 : cmd.y0;
               xe_in    = ($signed(x1) > $signed(fw_s)) ? fw_s : x1;
               ye_in    = ($signed(y1) > $signed(fh_s)) ? fh_s : y1;
               color_in = cmd.color;
               rd_in    = cmd.rd;
               state_in = SP_SETUP;
            end
         end
         SP_SETUP: begin
            if (empty) begin
               state_in = SP_DONE;
            end else begin
               x_in     = xs_ff[crfe_pkg::CFG_W-1:0];
               y_in     = ys_ff[crfe_pkg::CFG_W-1:0];
               row_in   = CW'(prod);
               state_in = SP_BASE;
            end
         end
         SP_BASE: begin
            row_in   = row_ff + CW'(xs_ff[crfe_pkg::CFG_W-1:0]);
            addr_in  = row_in;
            state_in = SP_WALK;
         end
         SP_WALK: begin
            if (x_last) begin
               if (y_last) begin
                  state_in = SP_DONE;
               end else begin
                  y_in    = y_ff + crfe_pkg::CFG_W'(1);
                  x_in    = xs_ff[crfe_pkg::CFG_W-1:0];
                  row_in  = row_ff + CW'(cfg.row_stride);
                  addr_in = row_in;
               end
            end else begin
               x_in    = x_ff + crfe_pkg::CFG_W'(1);
               addr_in = addr_ff + CW'(1);
            end
         end
         SP_DONE: begin
            state_in = SP_IDLE;
         end
         default: begin
            state_in = SP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SP_IDLE;
      end else begin
         state_ff <= state_in;
      end
      xs_ff    <= xs_in;
      xe_ff    <= xe_in;
      ys_ff    <= ys_in;
      ye_ff    <= ye_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      row_ff   <= row_in;
      addr_ff  <= addr_in;
      color_ff <= color_in;
      rd_ff    <= rd_in;
   end

   // Drop accesses that fall beyond the store
   assign mem_we    = (state_ff == SP_WALK) && !rd_ff && in_range;
   assign mem_re    = (state_ff == SP_WALK) && rd_ff && in_range;
   assign mem_addr  = addr_ff[AW-1:0];
   assign mem_wdata = color_ff;
   assign done      = (state_ff == SP_DONE);

endmodule

[hdl/clipped_rect_fill_engine.sv]
// Clipped rectangle fill engine: draws into a 16-bit frame store at x + y * stride.
// Command beats arrive on req_chan (mode, position, size, color); each command
// gives exactly one result beat on rsp_chan (read_color, in_frame). Register
// writes on csr_chan (index, data) are taken every cycle; write them only while
// the engine is idle.
// One command is worked at a time. The span walker writes one pixel per cycle;
// a span passes setup, row base, the pixel walk and done, and goes from setup
// straight to done when clipped away. The result beat goes valid as the
// engine returns to idle, so it can take the next command in the same cycle.
// An outline runs four spans in turn. Pixel write and read run as one-pixel
// spans; the read takes its color from the store's registered read port.
// The result sits in an output register: the next command is accepted while an
// earlier result waits, and a finished command holds in place until the output
// register is free, so a stalled receiver stalls the engine after one command.
// Reset (synchronous) returns the registers to 480 x 320 with stride 480 and
// drops any command in flight. The store is not cleared: pixels never written
// read back undefined.
module clipped_rect_fill_engine #(
   parameter int unsigned MAX_WIDTH  = crfe_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = crfe_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   crfe_req_if.sink    req_chan,
   crfe_rsp_if.source  rsp_chan,
   crfe_csr_if.sink    csr_chan
);

   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned SW    = crfe_pkg::SPAN_CW;
   localparam int unsigned CWD   = crfe_pkg::COORD_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LAUNCH = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_OUT    = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [1:0]                     seg_ff, seg_in;
   crfe_pkg::cfg_type              cfg_ff, cfg_in;
   logic [crfe_pkg::MODE_W-1:0]    mode_ff;
   logic [CWD-1:0]                 x_ff, y_ff;
   logic [crfe_pkg::SIZE_W-1:0]    w_ff, h_ff;
   logic [crfe_pkg::COLOR_W-1:0]   color_ff;
   logic                           hit_ff, hit_in;
   logic                           rd_issued_ff, rd_issued_in;
   logic [crfe_pkg::COLOR_W-1:0]   res_color_ff, res_color_in;
   logic                           res_frame_ff, res_frame_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [crfe_pkg::COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic                           rsp_frame_ff, rsp_frame_in;

   logic                           req_beat, out_free, last_seg;
   logic [SW-1:0]                  x13, y13, xw, yh;
   crfe_pkg::span_cmd_type         span_cmd;
   logic                           span_start, span_done;
   logic                           mem_we, mem_re;
   logic [AW-1:0]                  mem_addr;
   logic [crfe_pkg::COLOR_W-1:0]   mem_wdata, mem_rdata;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Register writes; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            crfe_pkg::CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_chan.data;
            crfe_pkg::CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_chan.data;
            crfe_pkg::CSR_ROW_STRIDE:   cfg_in.row_stride   = csr_chan.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Pixel commands hit when the position lies inside the frame
   assign hit_in = !req_chan.pos_x[CWD-1] && !req_chan.pos_y[CWD-1] &&
                   (req_chan.pos_x[CWD-2:0] < cfg_ff.frame_width) &&
                   (req_chan.pos_y[CWD-2:0] < cfg_ff.frame_height);

   // Build the span for the current command and outline segment
   always_comb begin
      x13 = {{(SW-CWD){x_ff[CWD-1]}}, x_ff};
      y13 = {{(SW-CWD){y_ff[CWD-1]}}, y_ff};
      xw  = x13 + SW'(w_ff);
      yh  = y13 + SW'(h_ff);
      span_cmd.x0    = x13;
      span_cmd.y0    = y13;
      span_cmd.w     = w_ff;
      span_cmd.h     = h_ff;
      span_cmd.color = color_ff;
      span_cmd.rd    = (mode_ff == crfe_pkg::MODE_READ);
      unique case (mode_ff)
         crfe_pkg::MODE_FILL: begin
            span_cmd.w = w_ff;
         end
         crfe_pkg::MODE_OUTLINE: begin
            unique case (seg_ff)
               2'd0: span_cmd.h = crfe_pkg::SIZE_W'(1);
               2'd1: begin
                  span_cmd.y0 = yh;
                  span_cmd.h  = crfe_pkg::SIZE_W'(1);
               end
               2'd2: span_cmd.w = crfe_pkg::SIZE_W'(1);
               2'd3: begin
                  span_cmd.x0 = xw;
                  span_cmd.w  = crfe_pkg::SIZE_W'(1);
               end
               default: span_cmd.w = w_ff;
            endcase
         end
         crfe_pkg::MODE_WRITE, crfe_pkg::MODE_READ: begin
            span_cmd.w = crfe_pkg::SIZE_W'(1);
            span_cmd.h = crfe_pkg::SIZE_W'(1);
         end
         default: span_cmd.w = w_ff;
      endcase
   end

   assign last_seg   = (mode_ff != crfe_pkg::MODE_OUTLINE) || (seg_ff == 2'd3);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign span_start = (state_ff == ST_LAUNCH);

   // Command sequencer and output register
   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      rd_issued_in = rd_issued_ff || mem_re;
      res_color_in = res_color_ff;
      res_frame_in = res_frame_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_color_in = rsp_color_ff;
      rsp_frame_in = rsp_frame_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               seg_in   = 2'd0;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            rd_issued_in = 1'b0;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (span_done) begin
               if (last_seg) begin
                  res_color_in = (span_cmd.rd && rd_issued_ff) ? mem_rdata : '0;
                  res_frame_in = mode_ff[1] && hit_ff;
                  state_in     = ST_OUT;
               end else begin
                  seg_in   = seg_ff + 2'd1;
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = res_color_ff;
               rsp_frame_in = res_frame_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff.frame_width  <= crfe_pkg::FRAME_WIDTH_RST;
         cfg_ff.frame_height <= crfe_pkg::FRAME_HEIGHT_RST;
         cfg_ff.row_stride   <= crfe_pkg::ROW_STRIDE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      if (req_beat) begin
         mode_ff  <= req_chan.mode;
         x_ff     <= req_chan.pos_x;
         y_ff     <= req_chan.pos_y;
         w_ff     <= req_chan.size_w;
         h_ff     <= req_chan.size_h;
         color_ff <= req_chan.color;
         hit_ff   <= hit_in;
      end
      seg_ff       <= seg_in;
      rd_issued_ff <= rd_issued_in;
      res_color_ff <= res_color_in;
      res_frame_ff <= res_frame_in;
      rsp_color_ff <= rsp_color_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_color = rsp_color_ff;
   assign rsp_chan.in_frame   = rsp_frame_ff;

   crfe_span #(
      .DEPTH (DEPTH)
   ) u_span (
      .clock     (clock),
      .reset     (reset),
      .start     (span_start),
      .cmd       (span_cmd),
      .cfg       (cfg_ff),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .done      (span_done)
   );

   crfe_ram #(
      .WIDTH (crfe_pkg::COLOR_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule
